@@ hw/rtl/ntc_pkg.sv @@
// Shared types and constants for the NTC thermistor temperature block.
// No dependencies; imported by ntc_div, ntc_core and ntc_thermistor_temperature.
`default_nettype none
package ntc_pkg;

  localparam int PULL_W    = 20;
  localparam int BETA_W    = 14;
  localparam int TEMP_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 20;
  localparam int LOG_W     = 22;   // Q16 log2, integer part below 64
  localparam int DV_W      = 40;   // signed Beta denominator
  localparam int DVD_W     = 53;   // dividend of the final division
  localparam int CNT_W     = 6;

  localparam logic [31:0] LN2_Q16        = 32'd45426;
  localparam logic [31:0] T0_CENTI_K     = 32'd29815;
  localparam logic [31:0] BETA_SCALE     = 32'd100;
  localparam logic [31:0] NV_SCALE       = 32'd2981500;
  localparam int          ZERO_C_CENTI_K = 27315;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BETA    = 3'd0,
    CFG_PULL    = 3'd1,
    CFG_NOMINAL = 3'd2,
    CFG_FLOOR   = 3'd3,
    CFG_CEILING = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_NUM,
    ST_MUL_DEN,
    ST_NORM,
    ST_SQR,
    ST_LN,
    ST_T1,
    ST_BK,
    ST_NV,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_CLAMP,
    ST_DONE
  } core_state_t;

  typedef struct packed {
    logic [BETA_W-1:0]        beta;
    logic [PULL_W-1:0]        pull;
    logic [PULL_W-1:0]        nominal;
    logic signed [TEMP_W-1:0] temp_floor;
    logic signed [TEMP_W-1:0] temp_ceiling;
  } cfg_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic                     err;
  } core_res_t;

endpackage
`default_nettype wire

@@ hw/rtl/ntc_thermistor_temperature.sv @@
// Top level: configuration registers, IIR filter, output register and ntc_core.
// Depends on ntc_pkg, ntc_core and ntc_div.
//
//  channel | signals                                  | direction
//  in      | in_valid in_ready adc_sample conversion_ok | sample beat in
//  out     | out_valid out_ready temperature_centi error_flag | result beat out
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data   | register write in
//
// A good sample goes from acceptance to result through two log2 passes (a
// multiply, normalize steps and squaring steps) on the shared multiplier, four multiply steps,
// and the one-bit-per-cycle divider. Error beats go straight to the result.
// in_ready is low while the sequencer works; the output register lets the next
// beat be taken while a result waits on out_ready. Reset is synchronous, clears
// the filter and loads register defaults; no clearing pass.
`default_nettype none
module ntc_thermistor_temperature #(
  parameter int SAMPLE_BITS   = 16,
  parameter int FILTER_SHIFT  = 4,
  parameter int FRACTION_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [15:0]                     adc_sample,
  input  logic                            conversion_ok,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [ntc_pkg::TEMP_W-1:0] temperature_centi,
  output logic                            error_flag,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ntc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ntc_pkg::CFG_DAT_W-1:0]   cfg_data
);
  import ntc_pkg::*;

  localparam int LW = SAMPLE_BITS + FRACTION_BITS;
  localparam logic [LW-1:0] FULL = {{SAMPLE_BITS{1'b1}}, {FRACTION_BITS{1'b0}}};

  cfg_t          cfg;
  logic [LW-1:0] level;
  logic [LW-1:0] level_next;
  logic [LW-1:0] samp;
  logic          accept;
  logic          start_err;
  logic          core_idle;
  logic          res_valid;
  core_res_t     res;
  logic          res_take;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign in_ready  = core_idle;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.beta         <= BETA_W'(3950);
      cfg.pull         <= PULL_W'(10000);
      cfg.nominal      <= PULL_W'(10000);
      cfg.temp_floor   <= '0;
      cfg.temp_ceiling <= TEMP_W'(15000);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BETA:    cfg.beta         <= cfg_data[BETA_W-1:0];
        CFG_PULL:    cfg.pull         <= cfg_data;
        CFG_NOMINAL: cfg.nominal      <= cfg_data;
        CFG_FLOOR:   cfg.temp_floor   <= cfg_data[TEMP_W-1:0];
        CFG_CEILING: cfg.temp_ceiling <= cfg_data[TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Low-pass step toward the scaled sample
  always_comb begin
    samp = {adc_sample[SAMPLE_BITS-1:0], {FRACTION_BITS{1'b0}}};
    if (samp >= level) level_next = level + ((samp - level) >> FILTER_SHIFT);
    else               level_next = level - ((level - samp) >> FILTER_SHIFT);
    start_err = !conversion_ok || (level_next == '0) || (level_next >= FULL);
  end

  // Hold the filter on a timed-out beat
  always_ff @(posedge clk) begin
    if (rst)                         level <= '0;
    else if (accept && conversion_ok) level <= level_next;
  end

  ntc_core #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .start_err (start_err),
    .level     (level_next),
    .cfg       (cfg),
    .idle      (core_idle),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // Output register
  assign res_take = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst)                       out_valid <= 1'b0;
    else if (res_take)             out_valid <= 1'b1;
    else if (out_ready)            out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      temperature_centi <= res.err ? '0 : res.temp;
      error_flag        <= res.err;
    end
  end

  // Error beats report zero temperature
  assert property (@(posedge clk) disable iff (rst)
    out_valid && error_flag |-> temperature_centi == '0)
    else $error("error beat with nonzero temperature");

  // Good results never exceed the ceiling
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !error_flag |-> temperature_centi <= cfg.temp_ceiling)
    else $error("result above ceiling");

  // An accepted beat occupies the sequencer
  assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("ready right after accept");

  // A result moves to the output only when the slot is free
  assert property (@(posedge clk) disable iff (rst)
    res_take |-> !out_valid || out_ready)
    else $error("output overwritten");

endmodule
`default_nettype wire

@@ hw/rtl/ntc_div.sv @@
// Restoring divider, one quotient bit per cycle, for the Beta equation.
// Depends on ntc_pkg for widths.
`default_nettype none
module ntc_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ntc_pkg::DVD_W-1:0] dividend,
  input  logic [ntc_pkg::DV_W-2:0]  divisor,
  output logic                      done,
  output logic [ntc_pkg::DVD_W-1:0] quotient
);
  import ntc_pkg::*;

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [DVD_W-1:0]   dd;
  logic [DV_W-2:0]    dsr;
  logic [DV_W-1:0]    rem;
  logic [DV_W-1:0]    rem_sh;
  logic               fits;

  // Shift in the next dividend bit and trial subtract
  always_comb begin
    rem_sh = {rem[DV_W-2:0], dd[DVD_W-1]};
    fits   = rem_sh >= {1'b0, dsr};
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits shift into the dividend register
  always_ff @(posedge clk) begin
    if (start) begin
      dd  <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? rem_sh - {1'b0, dsr} : rem_sh;
      dd  <= {dd[DVD_W-2:0], fits};
    end
  end

  assign quotient = dd;

endmodule
`default_nettype wire

@@ hw/rtl/ntc_core.sv @@
// Sequencer and datapath around one shared 32x32 multiplier: log2 of the
// divider terms, ln ratio, Beta equation and clamp. Uses ntc_pkg and ntc_div.
`default_nettype none
module ntc_core #(
  parameter int SAMPLE_BITS   = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic                                  start_err,
  input  logic [SAMPLE_BITS+FRACTION_BITS-1:0]  level,
  input  ntc_pkg::cfg_t                         cfg,
  output logic                                  idle,
  output logic                                  res_valid,
  output ntc_pkg::core_res_t                    res,
  input  logic                                  res_take
);
  import ntc_pkg::*;

  localparam int LW = SAMPLE_BITS + FRACTION_BITS;
  localparam int VW = PULL_W + LW;
  localparam logic [LW-1:0] FULL = {{SAMPLE_BITS{1'b1}}, {FRACTION_BITS{1'b0}}};

  core_state_t state, state_next;

  logic [LW-1:0]        xr;
  logic [VW-1:0]        vreg;
  logic [5:0]           lz;
  logic [3:0]           cnt;
  logic                 sel_den;
  logic [30:0]          m;
  logic [15:0]          frac;
  logic [LOG_W-1:0]     lnum;
  logic [LOG_W-1:0]     lden;
  logic [LOG_W-1:0]     lnq_mag;
  logic                 lnq_neg;
  logic [36:0]          t1;
  logic [20:0]          bk;
  logic [35:0]          nvb;
  logic signed [DV_W-1:0] dv;
  logic signed [TEMP_W-1:0] temp_r;
  logic                 err_r;

  logic [31:0]          mul_a;
  logic [31:0]          mul_b;
  logic [63:0]          prod;
  logic [5:0]           sz;
  logic [6:0]           hs;
  logic                 hi_zero;
  logic [VW-1:0]        norm_next;
  logic [31:0]          sq;
  logic [30:0]          m_next;
  logic [15:0]          frac_next;
  logic [5:0]           p;
  logic signed [LOG_W:0] d;
  logic [LOG_W-1:0]     dmag;
  logic                 dv_nonpos;
  logic                 div_start;
  logic                 div_done;
  logic [DVD_W-1:0]     quo;
  logic signed [DVD_W+1:0] tq;
  logic signed [DVD_W+1:0] fl;
  logic signed [DVD_W+1:0] cl;
  logic signed [DVD_W+1:0] tf;
  logic signed [DVD_W+1:0] tc;

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_MUL_NUM: begin
        mul_a = 32'(cfg.pull);
        mul_b = 32'(xr);
      end
      ST_MUL_DEN: begin
        mul_a = 32'(cfg.nominal);
        mul_b = 32'(FULL - xr);
      end
      ST_SQR: begin
        mul_a = {1'b0, m};
        mul_b = {1'b0, m};
      end
      ST_LN: begin
        mul_a = 32'(dmag);
        mul_b = LN2_Q16;
      end
      ST_T1: begin
        mul_a = 32'(lnq_mag);
        mul_b = T0_CENTI_K;
      end
      ST_BK: begin
        mul_a = 32'(cfg.beta);
        mul_b = BETA_SCALE;
      end
      ST_NV: begin
        mul_a = 32'(cfg.beta);
        mul_b = NV_SCALE;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = 64'(mul_a) * 64'(mul_b);
  end

  // Normalize step, squaring step, log difference and clamp
  always_comb begin
    sz        = 6'd32 >> cnt[2:0];
    hs        = 7'(VW) - {1'b0, sz};
    hi_zero   = (vreg >> hs) == '0;
    norm_next = hi_zero ? (vreg << sz) : vreg;
    sq        = prod[61:30];
    m_next    = sq[31] ? sq[31:1] : sq[30:0];
    frac_next = {frac[14:0], sq[31]};
    p         = 6'(VW - 1) - lz;
    d         = $signed({1'b0, lnum}) - $signed({1'b0, lden});
    dmag      = d[LOG_W] ? LOG_W'(-d) : d[LOG_W-1:0];
    dv_nonpos = dv[DV_W-1] || (dv == '0);
    div_start = (state == ST_DIV_GO) && !dv_nonpos;
    tq        = $signed({2'b00, quo}) - (DVD_W+2)'(ZERO_C_CENTI_K);
    fl        = (DVD_W+2)'(cfg.temp_floor);
    cl        = (DVD_W+2)'(cfg.temp_ceiling);
    tf        = (tq < fl) ? fl : tq;
    tc        = (tf > cl) ? cl : tf;
  end

  ntc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({nvb, 16'b0} + DVD_W'(dv[DV_W-1:1])),
    .divisor  (dv[DV_W-2:0]),
    .done     (div_done),
    .quotient (quo)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (start) state_next = start_err ? ST_DONE : ST_MUL_NUM;
      ST_MUL_NUM:  state_next = ST_NORM;
      ST_MUL_DEN:  state_next = ST_NORM;
      ST_NORM:     if (cnt == 4'd5) state_next = ST_SQR;
      ST_SQR:      if (cnt == 4'd15) state_next = sel_den ? ST_LN : ST_MUL_DEN;
      ST_LN:       state_next = ST_T1;
      ST_T1:       state_next = ST_BK;
      ST_BK:       state_next = ST_NV;
      ST_NV:       state_next = ST_DIV_GO;
      ST_DIV_GO:   state_next = dv_nonpos ? ST_DONE : ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_done) state_next = ST_CLAMP;
      ST_CLAMP:    state_next = ST_DONE;
      ST_DONE:     if (res_take) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  assign idle      = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);
  assign res.temp  = temp_r;
  assign res.err   = err_r;

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          xr     <= level;
          err_r  <= start_err;
          temp_r <= '0;
        end
      end
      ST_MUL_NUM, ST_MUL_DEN: begin
        vreg    <= (prod[VW-1:0] == '0) ? VW'(1) : prod[VW-1:0];
        lz      <= '0;
        cnt     <= '0;
        frac    <= '0;
        sel_den <= (state == ST_MUL_DEN);
      end
      ST_NORM: begin
        vreg <= norm_next;
        if (hi_zero) lz <= lz + sz;
        m    <= norm_next[VW-1 -: 31];
        cnt  <= (cnt == 4'd5) ? 4'd0 : cnt + 4'd1;
      end
      ST_SQR: begin
        m    <= m_next;
        frac <= frac_next;
        cnt  <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          if (sel_den) lden <= {p, frac_next};
          else         lnum <= {p, frac_next};
        end
      end
      ST_LN: begin
        lnq_mag <= prod[LOG_W+15:16];
        lnq_neg <= d[LOG_W];
      end
      ST_T1: t1 <= prod[36:0];
      ST_BK: bk <= prod[20:0];
      ST_NV: begin
        nvb <= prod[35:0];
        dv  <= lnq_neg ? $signed(DV_W'({bk, 16'b0}) - DV_W'(t1))
                       : $signed(DV_W'({bk, 16'b0}) + DV_W'(t1));
      end
      ST_DIV_GO: if (dv_nonpos) temp_r <= cfg.temp_ceiling;
      ST_CLAMP:  temp_r <= tc[TEMP_W-1:0];
      default: ;
    endcase
  end

endmodule
`default_nettype wire
